### rtl/selective_repeat_chunk_tracker_top_defines.svh
// Assertion macros for the chunk tracker checker.
`ifndef SELECTIVE_REPEAT_CHUNK_TRACKER_TOP_DEFINES_SVH
`define SELECTIVE_REPEAT_CHUNK_TRACKER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/srct_pkg.sv
// Shared types and constants of the chunk tracker.
package srct_pkg;

   localparam int FUNC_W        = 2;
   localparam int FRAME_BYTES_W = 18;
   localparam int IMG_TAG_W     = 16;
   localparam int CHUNK_INDEX_W = 16;
   localparam int SENT_CHUNK_W  = 12;
   localparam int COUNT_OUT_W   = 13;
   localparam int MAP_BIT_W     = 5;
   localparam int MAP_WORD_BITS = 32;

   typedef logic [FUNC_W-1:0] func_type;

   localparam func_type FUNC_NEW_IMAGE = 2'd0;
   localparam func_type FUNC_STEP      = 2'd1;
   localparam func_type FUNC_REQUEST   = 2'd2;
   localparam func_type FUNC_SWEEP     = 2'd3;

endpackage

### rtl/selective_repeat_chunk_tracker_top.sv
// Selective-repeat chunk tracker: first-pass sequencing, request bitmap and resend sweep.
//
// A transaction is taken when start is high and busy is low; its result appears after the
// execute state for exactly one cycle, marked by rsp_valid, and cannot be held off. Step,
// request and sweep transactions take one read of the request bitmap word, then the modify
// and write-back. A new image with a nonzero byte count also clears the bitmap (MAP_WORDS =
// ceil(MAX_CHUNKS / 32) words, 128 by default): its result comes out as for the other
// transactions and busy then stays high while the bitmap is cleared one word a cycle. An
// empty image clears nothing. After reset, busy is high while the bitmap is cleared.
module selective_repeat_chunk_tracker_top #(
   parameter int MAX_CHUNKS  = 4096,
   parameter int CHUNK_BYTES = 56
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [srct_pkg::FUNC_W-1:0]              req_func,
   input  logic [srct_pkg::FRAME_BYTES_W-1:0]       req_frame_bytes,
   input  logic                                     req_chunk_available,
   input  logic [srct_pkg::IMG_TAG_W-1:0]           req_img_tag,
   input  logic [srct_pkg::CHUNK_INDEX_W-1:0]       req_chunk_index,
   output logic                                     rsp_valid,
   output logic                                     rsp_send,
   output logic [srct_pkg::SENT_CHUNK_W-1:0]        rsp_sent_chunk,
   output logic [srct_pkg::IMG_TAG_W-1:0]           rsp_img_tag,
   output logic [srct_pkg::COUNT_OUT_W-1:0]         rsp_chunks_total,
   output logic [srct_pkg::COUNT_OUT_W-1:0]         rsp_pending,
   output logic                                     rsp_active,
   output logic                                     rsp_accepted,
   output logic                                     rsp_pass_open
);

   localparam int MAP_WORDS =
      (MAX_CHUNKS + srct_pkg::MAP_WORD_BITS - 1) / srct_pkg::MAP_WORD_BITS;
   localparam int WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
   localparam int NUM_W     = srct_pkg::FRAME_BYTES_W + 1;
   localparam int DIV_SHIFT = NUM_W + $clog2(CHUNK_BYTES);
   localparam int MULT_W    = DIV_SHIFT + 1;
   localparam int PROD_W    = NUM_W + MULT_W;

   localparam logic [63:0] DIV_MULT_FULL =
      ((64'd1 << DIV_SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);
   localparam logic [MULT_W-1:0] DIV_MULT  = DIV_MULT_FULL[MULT_W-1:0];
   localparam logic [NUM_W-1:0]  ROUND_UP  = NUM_W'(CHUNK_BYTES - 1);
   localparam logic [NUM_W-1:0]  MAX_QUOT  = NUM_W'(MAX_CHUNKS);
   localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_CHUNKS);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0]                           state_ff, state_in;
   logic [WORD_W-1:0]                    clr_addr_ff, clr_addr_in;
   logic [srct_pkg::IMG_TAG_W-1:0]       image_ff, image_in;
   logic [CNT_W-1:0]                     next_ff, next_in;
   logic [CNT_W-1:0]                     pass_ff, pass_in;
   logic [CNT_W-1:0]                     total_ff, total_in;
   logic [CNT_W-1:0]                     pending_ff, pending_in;

   srct_pkg::func_type                   op_func_ff;
   logic                                 op_nonzero_ff;
   logic                                 op_avail_ff;
   logic [srct_pkg::IMG_TAG_W-1:0]       op_id_ff;
   logic [srct_pkg::CHUNK_INDEX_W-1:0]   op_idx_ff;
   logic [PROD_W-1:0]                    prod_ff;

   logic [srct_pkg::MAP_WORD_BITS-1:0]   map_mem [MAP_WORDS];
   logic [srct_pkg::MAP_WORD_BITS-1:0]   rd_word_ff;
   logic                                 mem_we;
   logic [WORD_W-1:0]                    mem_waddr;
   logic [srct_pkg::MAP_WORD_BITS-1:0]   mem_wdata;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_send_ff, send_in;
   logic [srct_pkg::SENT_CHUNK_W-1:0]    rsp_sent_ff, sent_in;
   logic                                 rsp_accepted_ff, accepted_in;
   logic [srct_pkg::IMG_TAG_W-1:0]       rsp_image_ff;
   logic [srct_pkg::COUNT_OUT_W-1:0]     rsp_total_ff;
   logic [srct_pkg::COUNT_OUT_W-1:0]     rsp_pending_ff;
   logic                                 rsp_active_ff;
   logic                                 rsp_pass_open_ff;

   logic                                 accept;
   logic [NUM_W-1:0]                     numer;
   logic [NUM_W-1:0]                     quot;
   logic [CNT_W-1:0]                     chunk_count;
   logic [CNT_W-1:0]                     next_plus;
   logic [WORD_W-1:0]                    op_word;
   logic                                 idx_in_range;
   logic                                 bit_set;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign numer       = NUM_W'(req_frame_bytes) + ROUND_UP;
   assign quot        = prod_ff[DIV_SHIFT +: NUM_W];
   assign chunk_count = (quot > MAX_QUOT) ? MAX_CNT : quot[CNT_W-1:0];
   assign next_plus   = next_ff + CNT_W'(1);
   assign op_word     = op_idx_ff[srct_pkg::MAP_BIT_W +: WORD_W];
   assign idx_in_range = (32'(op_idx_ff) < 32'(total_ff));
   assign bit_set     = rd_word_ff[op_idx_ff[srct_pkg::MAP_BIT_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      image_in     = image_ff;
      next_in      = next_ff;
      pass_in      = pass_ff;
      total_in     = total_ff;
      pending_in   = pending_ff;
      rsp_valid_in = 1'b0;
      send_in      = 1'b0;
      sent_in      = '0;
      accepted_in  = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = op_word;
      mem_wdata    = rd_word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            unique case (op_func_ff)
               srct_pkg::FUNC_NEW_IMAGE: begin
                  if (op_nonzero_ff) begin
                     image_in    = image_ff + srct_pkg::IMG_TAG_W'(1);
                     next_in     = '0;
                     pass_in     = chunk_count;
                     total_in    = chunk_count;
                     pending_in  = '0;
                     accepted_in = 1'b1;
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
               end
               srct_pkg::FUNC_STEP: begin
                  if (pass_ff != '0) begin
                     if (!op_avail_ff) begin
                        pass_in = '0;
                     end else begin
                        send_in = 1'b1;
                        sent_in = srct_pkg::SENT_CHUNK_W'(next_ff);
                        next_in = next_plus;
                        if (next_plus >= pass_ff) begin
                           pass_in = '0;
                        end
                     end
                  end
               end
               srct_pkg::FUNC_REQUEST: begin
                  if (op_id_ff == image_ff && idx_in_range && !bit_set) begin
                     mem_we = 1'b1;
                     mem_wdata[op_idx_ff[srct_pkg::MAP_BIT_W-1:0]] = 1'b1;
                     pending_in  = pending_ff + CNT_W'(1);
                     accepted_in = 1'b1;
                  end
               end
               srct_pkg::FUNC_SWEEP: begin
                  if (pass_ff == '0 && pending_ff != '0 && idx_in_range && bit_set) begin
                     mem_we = 1'b1;
                     mem_wdata[op_idx_ff[srct_pkg::MAP_BIT_W-1:0]] = 1'b0;
                     pending_in = pending_ff - CNT_W'(1);
                     send_in    = 1'b1;
                     sent_in    = srct_pkg::SENT_CHUNK_W'(op_idx_ff);
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CLEAR: begin
            // wipe the bitmap one word a cycle
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            if (clr_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + WORD_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         image_ff     <= '0;
         next_ff      <= '0;
         pass_ff      <= '0;
         total_ff     <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         image_ff     <= image_in;
         next_ff      <= next_in;
         pass_ff      <= pass_in;
         total_ff     <= total_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the transaction and the registered product for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_func_ff    <= req_func;
         op_nonzero_ff <= (req_frame_bytes != '0);
         op_avail_ff   <= req_chunk_available;
         op_id_ff      <= req_img_tag;
         op_idx_ff     <= req_chunk_index;
         prod_ff       <= PROD_W'(numer) * PROD_W'(DIV_MULT);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= map_mem[req_chunk_index[srct_pkg::MAP_BIT_W +: WORD_W]];
   end

   always_ff @(posedge clock) begin
      rsp_send_ff      <= send_in;
      rsp_sent_ff      <= sent_in;
      rsp_accepted_ff  <= accepted_in;
      rsp_image_ff     <= image_in;
      rsp_total_ff     <= srct_pkg::COUNT_OUT_W'(total_in);
      rsp_pending_ff   <= srct_pkg::COUNT_OUT_W'(pending_in);
      rsp_active_ff    <= (pass_in != '0) || (pending_in != '0);
      rsp_pass_open_ff <= (pass_in != '0);
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_send         = rsp_send_ff;
   assign rsp_sent_chunk   = rsp_sent_ff;
   assign rsp_img_tag      = rsp_image_ff;
   assign rsp_chunks_total = rsp_total_ff;
   assign rsp_pending      = rsp_pending_ff;
   assign rsp_active       = rsp_active_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_pass_open    = rsp_pass_open_ff;

endmodule

### rtl/srct_checker.sv
// Port-level checker for the chunk tracker, bound to the top level.
`include "selective_repeat_chunk_tracker_top_defines.svh"

module srct_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_send,
   input logic [11:0] rsp_sent_chunk,
   input logic        rsp_active,
   input logic        rsp_pass_open
);

   // every accepted transaction gives its result
   `SRCT_ASSERT_SAME(a_result_latency, clock, reset, start && !busy, ##2 rsp_valid,
                     "missing result")

   `SRCT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid,
                     "result strobe too long")

   `SRCT_ASSERT_SAME(a_idle_chunk, clock, reset, rsp_valid && !rsp_send,
                     rsp_sent_chunk == 12'd0, "chunk index without send")

   `SRCT_ASSERT_SAME(a_pass_active, clock, reset, rsp_valid && rsp_pass_open, rsp_active,
                     "open pass not active")

endmodule

bind selective_repeat_chunk_tracker_top srct_checker u_srct_checker (.*);

### sim/tb_selective_repeat_chunk_tracker_top.sv
// Self-checking testbench for the chunk tracker: directed table, then random image sessions.
`timescale 1ns / 1ps

module tb_selective_repeat_chunk_tracker_top;

   localparam int MAX_CHUNKS  = 4096;
   localparam int CHUNK_BYTES = 56;
   localparam int MAP_WORDS   = (MAX_CHUNKS + 31) / 32;
   localparam int ITEM_GOAL   = 600;

   typedef struct packed {
      srct_pkg::func_type                    func;
      logic [srct_pkg::FRAME_BYTES_W-1:0]    frame_bytes;
      logic                                  chunk_available;
      logic [srct_pkg::IMG_TAG_W-1:0]        img_tag;
      logic [srct_pkg::CHUNK_INDEX_W-1:0]    chunk_index;
   } chunk_item_type;

   typedef struct packed {
      logic                                  send;
      logic [srct_pkg::SENT_CHUNK_W-1:0]     sent_chunk;
      logic [srct_pkg::IMG_TAG_W-1:0]        img_tag;
      logic [srct_pkg::COUNT_OUT_W-1:0]      chunks_total;
      logic [srct_pkg::COUNT_OUT_W-1:0]      pending;
      logic                                  active;
      logic                                  accepted;
      logic                                  pass_open;
   } chunk_outcome_type;

   typedef struct packed {
      chunk_item_type    item;
      logic              typed;
      chunk_outcome_type outcome;
   } stim_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic [srct_pkg::FUNC_W-1:0]         req_func;
   logic [srct_pkg::FRAME_BYTES_W-1:0]  req_frame_bytes;
   logic                                req_chunk_available;
   logic [srct_pkg::IMG_TAG_W-1:0]      req_img_tag;
   logic [srct_pkg::CHUNK_INDEX_W-1:0]  req_chunk_index;
   logic                                rsp_valid;
   logic                                rsp_send;
   logic [srct_pkg::SENT_CHUNK_W-1:0]   rsp_sent_chunk;
   logic [srct_pkg::IMG_TAG_W-1:0]      rsp_img_tag;
   logic [srct_pkg::COUNT_OUT_W-1:0]    rsp_chunks_total;
   logic [srct_pkg::COUNT_OUT_W-1:0]    rsp_pending;
   logic                                rsp_active;
   logic                                rsp_accepted;
   logic                                rsp_pass_open;

   // tracker state as the checker sees it
   logic [srct_pkg::IMG_TAG_W-1:0]      cur_image;
   logic [srct_pkg::COUNT_OUT_W-1:0]    first_next;
   logic [srct_pkg::COUNT_OUT_W-1:0]    open_chunks;
   logic [srct_pkg::COUNT_OUT_W-1:0]    image_chunks;
   logic [MAX_CHUNKS-1:0]               requested;
   logic [srct_pkg::COUNT_OUT_W-1:0]    outstanding;

   chunk_outcome_type awaited_outcomes[$];
   stim_row_type      directed_rows[$];

   int  mismatches;
   int  transactions;
   int  noise_items;
   int  results_seen;
   int  images_started;
   int  first_sends;
   int  resends;
   bit  burst_mode;

   selective_repeat_chunk_tracker_top #(
      .MAX_CHUNKS  (MAX_CHUNKS),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_func            (req_func),
      .req_frame_bytes     (req_frame_bytes),
      .req_chunk_available (req_chunk_available),
      .req_img_tag         (req_img_tag),
      .req_chunk_index     (req_chunk_index),
      .rsp_valid           (rsp_valid),
      .rsp_send            (rsp_send),
      .rsp_sent_chunk      (rsp_sent_chunk),
      .rsp_img_tag         (rsp_img_tag),
      .rsp_chunks_total    (rsp_chunks_total),
      .rsp_pending         (rsp_pending),
      .rsp_active          (rsp_active),
      .rsp_accepted        (rsp_accepted),
      .rsp_pass_open       (rsp_pass_open)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatches++;
      $display("MISMATCH @%0t: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   function automatic void clear_tracker();
      cur_image    = '0;
      first_next   = '0;
      open_chunks  = '0;
      image_chunks = '0;
      requested    = '0;
      outstanding  = '0;
   endfunction

   // Update the tracker copy with one transaction and return its result.
   function automatic chunk_outcome_type apply_to_tracker(input chunk_item_type it);
      chunk_outcome_type o;
      int unsigned       n;
      int unsigned       idx;
      o   = '0;
      idx = 32'(it.chunk_index);
      case (it.func)
         srct_pkg::FUNC_NEW_IMAGE: begin
            if (it.frame_bytes != 0) begin
               n = (int'(it.frame_bytes) + CHUNK_BYTES - 1) / CHUNK_BYTES;
               if (n > MAX_CHUNKS) n = MAX_CHUNKS;
               cur_image    = cur_image + 1'b1;
               first_next   = '0;
               open_chunks  = srct_pkg::COUNT_OUT_W'(n);
               image_chunks = srct_pkg::COUNT_OUT_W'(n);
               requested    = '0;
               outstanding  = '0;
               o.accepted   = 1'b1;
               images_started++;
            end
         end
         srct_pkg::FUNC_STEP: begin
            if (open_chunks != 0) begin
               if (!it.chunk_available) begin
                  open_chunks = '0;
               end else begin
                  o.send       = 1'b1;
                  o.sent_chunk = first_next[srct_pkg::SENT_CHUNK_W-1:0];
                  first_next   = first_next + 1'b1;
                  if (first_next >= open_chunks) open_chunks = '0;
                  first_sends++;
               end
            end
         end
         srct_pkg::FUNC_REQUEST: begin
            if (it.img_tag == cur_image && idx < image_chunks && idx < MAX_CHUNKS) begin
               if (!requested[idx]) begin
                  requested[idx] = 1'b1;
                  outstanding    = outstanding + 1'b1;
                  o.accepted     = 1'b1;
               end
            end
         end
         default: begin
            if (open_chunks == 0 && outstanding != 0 && idx < image_chunks) begin
               if (requested[idx]) begin
                  requested[idx] = 1'b0;
                  outstanding    = outstanding - 1'b1;
                  o.send         = 1'b1;
                  o.sent_chunk   = idx[srct_pkg::SENT_CHUNK_W-1:0];
                  resends++;
               end
            end
         end
      endcase
      o.img_tag      = cur_image;
      o.chunks_total = image_chunks;
      o.pending      = outstanding;
      o.active       = (open_chunks != 0) || (outstanding != 0);
      o.pass_open    = (open_chunks != 0);
      return o;
   endfunction

   function automatic chunk_item_type mk_item(input srct_pkg::func_type f,
                                              input int unsigned bytes, input bit avail,
                                              input int unsigned id, input int unsigned idx);
      chunk_item_type it;
      it.func            = f;
      it.frame_bytes     = srct_pkg::FRAME_BYTES_W'(bytes);
      it.chunk_available = avail;
      it.img_tag         = srct_pkg::IMG_TAG_W'(id);
      it.chunk_index     = srct_pkg::CHUNK_INDEX_W'(idx);
      return it;
   endfunction

   function automatic chunk_outcome_type mk_out(input bit snd, input int unsigned sent,
                                                input int unsigned img, input int unsigned total,
                                                input int unsigned pend, input bit actv,
                                                input bit acc, input bit open);
      chunk_outcome_type o;
      o.send         = snd;
      o.sent_chunk   = srct_pkg::SENT_CHUNK_W'(sent);
      o.img_tag      = srct_pkg::IMG_TAG_W'(img);
      o.chunks_total = srct_pkg::COUNT_OUT_W'(total);
      o.pending      = srct_pkg::COUNT_OUT_W'(pend);
      o.active       = actv;
      o.accepted     = acc;
      o.pass_open    = open;
      return o;
   endfunction

   function automatic void add_row(input chunk_item_type it, input bit typed,
                                   input chunk_outcome_type o);
      stim_row_type r;
      r.item    = it;
      r.typed   = typed;
      r.outcome = o;
      directed_rows.push_back(r);
   endfunction

   function automatic chunk_item_type random_item();
      chunk_item_type it;
      it.func            = srct_pkg::func_type'($urandom_range(0, 3));
      it.frame_bytes     = srct_pkg::FRAME_BYTES_W'($urandom);
      it.chunk_available = 1'($urandom);
      it.img_tag         = srct_pkg::IMG_TAG_W'($urandom);
      it.chunk_index     = srct_pkg::CHUNK_INDEX_W'($urandom);
      return it;
   endfunction

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   // Present one transaction, hold it until taken, then queue its result.
   task automatic drive_transaction(input chunk_item_type it, input bit typed,
                                    input chunk_outcome_type typed_out);
      chunk_outcome_type want;
      int                gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_func            <= it.func;
      req_frame_bytes     <= it.frame_bytes;
      req_chunk_available <= it.chunk_available;
      req_img_tag         <= it.img_tag;
      req_chunk_index     <= it.chunk_index;
      @(posedge clock);
      while (busy) @(posedge clock);
      want = apply_to_tracker(it);
      awaited_outcomes.push_back(typed ? typed_out : want);
      transactions++;
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic chunk_item_type request_item();
      chunk_item_type it;
      int unsigned    span;
      int unsigned    r;
      it   = random_item();
      span = (image_chunks > 48) ? 48 : 32'(image_chunks);
      r    = $urandom_range(0, 99);
      it.func = srct_pkg::FUNC_REQUEST;
      if (r < 85) it.img_tag = cur_image;
      if (span != 0 && (r < 75 || r >= 85))
         it.chunk_index = srct_pkg::CHUNK_INDEX_W'($urandom_range(0, span - 1));
      return it;
   endfunction

   task automatic send_noise();
      int n;
      n = $urandom_range(0, 2);
      repeat (n) begin
         drive_transaction(random_item(), 1'b0, '0);
         noise_items++;
      end
   endtask

   // One image: announce it, run the first pass, collect requests, sweep the resends.
   task automatic run_image_session();
      chunk_item_type it;
      int unsigned    r;
      int             steps;
      int             span;
      int             rounds;
      burst_mode = ($urandom_range(0, 3) == 0);
      send_noise();
      it      = random_item();
      it.func = srct_pkg::FUNC_NEW_IMAGE;
      r       = $urandom_range(0, 99);
      if (r < 5)
         it.frame_bytes = '0;
      else if (r < 10)
         it.frame_bytes = srct_pkg::FRAME_BYTES_W'($urandom_range(
            MAX_CHUNKS * CHUNK_BYTES - 60, (1 << srct_pkg::FRAME_BYTES_W) - 1));
      else
         it.frame_bytes = srct_pkg::FRAME_BYTES_W'($urandom_range(1, CHUNK_BYTES * 32));
      drive_transaction(it, 1'b0, '0);

      steps = 0;
      while (open_chunks != 0) begin
         r = $urandom_range(0, 9);
         if (r == 0) drive_transaction(request_item(), 1'b0, '0);
         else if (r == 1) begin
            it = random_item();
            it.func = srct_pkg::FUNC_SWEEP;
            drive_transaction(it, 1'b0, '0);
         end
         it      = random_item();
         it.func = srct_pkg::FUNC_STEP;
         // close long passes early
         it.chunk_available = (steps >= 40) ? 1'b0 : ($urandom_range(0, 24) != 0);
         drive_transaction(it, 1'b0, '0);
         steps++;
      end
      if ($urandom_range(0, 3) == 0) begin
         it      = random_item();
         it.func = srct_pkg::FUNC_STEP;
         drive_transaction(it, 1'b0, '0);
      end

      repeat ($urandom_range(1, 24)) drive_transaction(request_item(), 1'b0, '0);
      send_noise();

      span   = (image_chunks > 48) ? 48 : int'(image_chunks);
      rounds = $urandom_range(1, 2);
      repeat (rounds) begin
         for (int i = 0; i <= span + 1; i++) begin
            it             = random_item();
            it.func        = srct_pkg::FUNC_SWEEP;
            it.chunk_index = srct_pkg::CHUNK_INDEX_W'(i);
            drive_transaction(it, 1'b0, '0);
            if ($urandom_range(0, 19) == 0)
               drive_transaction(request_item(), 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin
      chunk_outcome_type got;
      chunk_outcome_type want;
      if (!reset && rsp_valid) begin
         got.send         = rsp_send;
         got.sent_chunk   = rsp_sent_chunk;
         got.img_tag      = rsp_img_tag;
         got.chunks_total = rsp_chunks_total;
         got.pending      = rsp_pending;
         got.active       = rsp_active;
         got.accepted     = rsp_accepted;
         got.pass_open    = rsp_pass_open;
         if (awaited_outcomes.size() == 0) begin
            flag_mismatch("result with no transaction outstanding", 1, 0);
         end else begin
            want = awaited_outcomes.pop_front();
            results_seen++;
            if (got.send !== want.send)
               flag_mismatch("send", 32'(got.send), 32'(want.send));
            if (got.sent_chunk !== want.sent_chunk)
               flag_mismatch("sent_chunk", 32'(got.sent_chunk), 32'(want.sent_chunk));
            if (got.img_tag !== want.img_tag)
               flag_mismatch("img_tag", 32'(got.img_tag), 32'(want.img_tag));
            if (got.chunks_total !== want.chunks_total)
               flag_mismatch("chunks_total", 32'(got.chunks_total), 32'(want.chunks_total));
            if (got.pending !== want.pending)
               flag_mismatch("pending", 32'(got.pending), 32'(want.pending));
            if (got.active !== want.active)
               flag_mismatch("active", 32'(got.active), 32'(want.active));
            if (got.accepted !== want.accepted)
               flag_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
            if (got.pass_open !== want.pass_open)
               flag_mismatch("pass_open", 32'(got.pass_open), 32'(want.pass_open));
         end
      end
   end

   initial begin
      int sessions;
      int waited;
      mismatches     = 0;
      transactions   = 0;
      noise_items    = 0;
      results_seen   = 0;
      images_started = 0;
      first_sends    = 0;
      resends        = 0;
      burst_mode     = 1'b0;
      clear_tracker();
      reset               <= 1'b1;
      start               <= 1'b0;
      req_func            <= srct_pkg::FUNC_NEW_IMAGE;
      req_frame_bytes     <= '0;
      req_chunk_available <= 1'b0;
      req_img_tag         <= '0;
      req_chunk_index     <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // nothing open after reset: step, empty image, request and sweep all do nothing
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_NEW_IMAGE, 0, 1, 0, 0), 1,
              mk_out(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 0), 1, mk_out(0, 0, 0, 0, 0, 0, 0, 0));
      // oversized image saturates the chunk count
      add_row(mk_item(srct_pkg::FUNC_NEW_IMAGE, 262143, 0, 0, 0), 1,
              mk_out(0, 0, 1, 4096, 0, 1, 1, 1));
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 1,
              mk_out(1, 0, 1, 4096, 0, 1, 0, 1));
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 1, 4095), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 1, 1));
      // repeated, stale and out-of-range requests, sweep with the pass open
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 1, 4095), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 1));
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 0, 3), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 1));
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 1, 4096), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 1));
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 1, 65535), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 1));
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 4095), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 1));
      // source exhausted closes the pass; a later step finds no pass; sweeps resend the requested chunk once
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 0, 0, 0), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 4094), 1,
              mk_out(0, 0, 1, 4096, 1, 1, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 4095), 1,
              mk_out(1, 4095, 1, 4096, 0, 0, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 4095), 1,
              mk_out(0, 0, 1, 4096, 0, 0, 0, 0));
      // exact chunk boundaries
      add_row(mk_item(srct_pkg::FUNC_NEW_IMAGE, 56, 0, 0, 0), 1,
              mk_out(0, 0, 2, 1, 0, 1, 1, 1));
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 1, mk_out(1, 0, 2, 1, 0, 0, 0, 0));
      add_row(mk_item(srct_pkg::FUNC_NEW_IMAGE, 229377, 0, 0, 0), 1,
              mk_out(0, 0, 3, 4096, 0, 1, 1, 1));
      add_row(mk_item(srct_pkg::FUNC_NEW_IMAGE, 57, 0, 0, 0), 0, '0);
      add_row(mk_item(srct_pkg::FUNC_REQUEST, 0, 0, 4, 1), 0, '0);
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 0, '0);
      add_row(mk_item(srct_pkg::FUNC_STEP, 0, 1, 0, 0), 0, '0);
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 2), 0, '0);
      add_row(mk_item(srct_pkg::FUNC_SWEEP, 0, 0, 0, 1), 0, '0);

      foreach (directed_rows[i])
         drive_transaction(directed_rows[i].item, directed_rows[i].typed,
                           directed_rows[i].outcome);
      drain_results();

      // stop a little short of the goal, since a session adds a batch at a time
      sessions = 0;
      while (transactions < ITEM_GOAL - 50) begin
         run_image_session();
         sessions++;
         // hold off now and then until every result is back
         if (sessions % 3 == 0) drain_results();
      end

      start <= 1'b0;
      waited = 0;
      while (awaited_outcomes.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (MAP_WORDS + 8) @(posedge clock);
      if (awaited_outcomes.size() != 0)
         flag_mismatch("results never delivered", 0, awaited_outcomes.size());

      $display("Covered %0d transactions (%0d random noise) over %0d images in %0d sessions",
               transactions, noise_items, images_started, sessions);
      $display("Checked %0d results: %0d first-pass chunks, %0d resends, %0d mismatches",
               results_seen, first_sends, resends, mismatches);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/srct_pkg.sv
rtl/selective_repeat_chunk_tracker_top.sv
rtl/srct_checker.sv
sim/tb_selective_repeat_chunk_tracker_top.sv
